@@ hdl/tesp_pkg.sv @@
// Shared types and constants of the terminal escape sequence parser.
`default_nettype none

package tesp_pkg;

    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 3;
    localparam int POS_W   = 4;
    localparam int VAL_W   = 14;
    localparam int TDATA_W = 48;
    localparam int TUSER_W = 4;
    localparam int RUN_CAP = 16;

    localparam logic [KIND_W-1:0] KIND_PRINT   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_EXECUTE = 3'd1;
    localparam logic [KIND_W-1:0] KIND_SUBST   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_ESC     = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CSI     = 3'd4;
    localparam logic [KIND_W-1:0] KIND_OSC     = 3'd5;
    localparam logic [KIND_W-1:0] KIND_OSC_END = 3'd6;

    localparam logic [BYTE_W-1:0] CH_BEL      = 8'h07;
    localparam logic [BYTE_W-1:0] CH_CAN      = 8'h18;
    localparam logic [BYTE_W-1:0] CH_SUB      = 8'h1A;
    localparam logic [BYTE_W-1:0] CH_ESC      = 8'h1B;
    localparam logic [BYTE_W-1:0] CH_C0_MAX   = 8'h1F;
    localparam logic [BYTE_W-1:0] CH_INT_MAX  = 8'h2F;
    localparam logic [BYTE_W-1:0] CH_COLON    = 8'h3A;
    localparam logic [BYTE_W-1:0] CH_SEMI     = 8'h3B;
    localparam logic [BYTE_W-1:0] CH_QUEST    = 8'h3F;
    localparam logic [BYTE_W-1:0] CH_FIN_MIN  = 8'h40;
    localparam logic [BYTE_W-1:0] CH_DCS      = 8'h50;
    localparam logic [BYTE_W-1:0] CH_SOS      = 8'h58;
    localparam logic [BYTE_W-1:0] CH_CSI      = 8'h5B;
    localparam logic [BYTE_W-1:0] CH_OSC      = 8'h5D;
    localparam logic [BYTE_W-1:0] CH_PM       = 8'h5E;
    localparam logic [BYTE_W-1:0] CH_APC      = 8'h5F;
    localparam logic [BYTE_W-1:0] CH_FIN_MAX  = 8'h7E;
    localparam logic [BYTE_W-1:0] INTER_OVFL  = 8'hFF;

    localparam logic [VAL_W-1:0] PARAM_SAT = 14'd16383;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] code;
        logic [BYTE_W-1:0] inter0;
        logic [BYTE_W-1:0] inter1;
        logic              priv;
        logic [POS_W-1:0]  last_pos;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic csi_done;
    } front_stat_t;

endpackage

`default_nettype wire

@@ hdl/terminal_escape_sequence_parser_top.sv @@
// Top level of the terminal escape sequence parser.
// The block accepts one terminal byte per cycle unless stalled and tokenizes it into
// print, control, substitute, escape dispatch, OSC byte, OSC end and CSI dispatch
// transactions. A front end tracks the sequence state and queues at most one command
// per byte in a two-entry queue; a back end drives the output register. A CSI
// dispatch with n parameters produces n transactions (at most MAX_PARAMS), one per
// cycle while the output side keeps up, as the back end walks the parameter store one
// entry per cycle; the input stays stalled from the final byte until the last of
// those entries has been read.
`default_nettype none

module terminal_escape_sequence_parser_top
    import tesp_pkg::*;
#(
    parameter int MAX_PARAMS = 16,
    parameter int OSC_LIMIT  = 510
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [7:0]         s_tdata,   // [7:0] in_byte
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    // [7:0] char_code, [15:8] first_inter, [23:16] second_inter, [27:24] param_pos,
    // [41:28] param_value, [47:42] zero
    output logic [TDATA_W-1:0]      m_tdata,
    output logic [TUSER_W-1:0]      m_tuser,   // [2:0] kind, [3] private_seq
    output logic                    m_tlast
);

    front_stat_t      stat;
    logic             push;
    cmd_t             push_cmd;
    logic             q_valid;
    logic             q_pop;
    logic             q_full;
    logic             csi_done;
    logic [$bits(cmd_t)-1:0] q_head;
    logic [POS_W-1:0] rd_pos;
    logic [VAL_W-1:0] rd_value;

    assign stat.full     = q_full;
    assign stat.csi_done = csi_done;

    tesp_front #(
        .MAX_PARAMS (MAX_PARAMS),
        .OSC_LIMIT  (OSC_LIMIT)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .in_byte  (s_tdata),
        .stat     (stat),
        .push     (push),
        .cmd      (push_cmd),
        .rd_pos   (rd_pos),
        .rd_value (rd_value)
    );

    tesp_queue #(
        .WIDTH ($bits(cmd_t))
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_cmd),
        .pop       (q_pop),
        .full      (q_full),
        .valid     (q_valid),
        .head      (q_head)
    );

    tesp_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_cmd    (cmd_t'(q_head)),
        .q_pop    (q_pop),
        .csi_done (csi_done),
        .rd_pos   (rd_pos),
        .rd_value (rd_value),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

@@ hdl/tesp_queue.sv @@
// Two-entry command queue between the parser front end and the result back end.
`default_nettype none

module tesp_queue
    import tesp_pkg::*;
#(
    parameter int WIDTH = 32
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    input  wire logic             pop,
    output logic                  full,
    output logic                  valid,
    output logic [WIDTH-1:0]      head
);

    logic [WIDTH-1:0] slot_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;

    assign full  = (count_reg == 2'd2);
    assign valid = (count_reg != 2'd0);
    assign head  = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

@@ hdl/tesp_front.sv @@
// Parser front end: takes bytes, tracks the sequence state and queues result commands.
`default_nettype none

module tesp_front
    import tesp_pkg::*;
#(
    parameter int MAX_PARAMS = 16,
    parameter int OSC_LIMIT  = 510
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [BYTE_W-1:0] in_byte,
    input  wire front_stat_t       stat,
    output logic                   push,
    output cmd_t                   cmd,
    input  wire logic [POS_W-1:0]  rd_pos,
    output logic [VAL_W-1:0]       rd_value
);

    localparam int XW = $clog2(MAX_PARAMS + 1);
    localparam int IW = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
    localparam int CW = $clog2(OSC_LIMIT + 1);

    typedef enum logic [3:0] {
        ST_GROUND,
        ST_ESC,
        ST_ESC_INTER,
        ST_CSI_ENTRY,
        ST_CSI_PARAM,
        ST_CSI_INTER,
        ST_CSI_IGNORE,
        ST_OSC,
        ST_ABSORB
    } state_t;

    state_t            state_reg, state_next;
    logic [BYTE_W-1:0] inter0_reg, inter0_next;
    logic [BYTE_W-1:0] inter1_reg, inter1_next;
    logic [VAL_W-1:0]  cur_reg, cur_next;
    logic [XW-1:0]     idx_reg, idx_next;
    logic [CW-1:0]     osc_cnt_reg, osc_cnt_next;
    logic              hold_reg, hold_next;
    logic [VAL_W-1:0]  store_reg [MAX_PARAMS];
    logic              store_we;

    logic              accept;
    logic [BYTE_W-1:0] b;
    logic [BYTE_W-1:0] base0, base1, coll0, coll1;
    logic [17:0]       acc;
    logic              idx_room;
    int                last_pos_int;

    assign s_tready = !hold_reg && !stat.full;
    assign accept   = s_tvalid && s_tready;
    assign b        = in_byte;
    assign idx_room = (int'(idx_reg) < MAX_PARAMS);
    assign acc      = 18'(cur_reg) * 18'd10 + 18'(b[3:0]);

    assign rd_value = (int'(rd_pos) == int'(idx_reg)) ? cur_reg : store_reg[IW'(rd_pos)];

    always_comb begin
        base0 = (state_reg == ST_ESC) ? '0 : inter0_reg;
        base1 = (state_reg == ST_ESC) ? '0 : inter1_reg;
        if (base0 == '0) begin
            coll0 = b;
            coll1 = base1;
        end else if (base1 == '0) begin
            coll0 = base0;
            coll1 = b;
        end else begin
            coll0 = INTER_OVFL;
            coll1 = base1;
        end
        last_pos_int = int'(idx_reg);
        if (last_pos_int > MAX_PARAMS - 1) begin
            last_pos_int = MAX_PARAMS - 1;
        end
        if (last_pos_int > RUN_CAP - 1) begin
            last_pos_int = RUN_CAP - 1;
        end
    end

    always_comb begin
        state_next   = state_reg;
        inter0_next  = inter0_reg;
        inter1_next  = inter1_reg;
        cur_next     = cur_reg;
        idx_next     = idx_reg;
        osc_cnt_next = osc_cnt_reg;
        hold_next    = hold_reg;
        store_we     = 1'b0;
        push         = 1'b0;
        cmd          = '0;

        if (stat.csi_done) begin
            hold_next = 1'b0;
        end

        if (accept) begin
            cmd.code = b;
            if (b == CH_CAN || b == CH_SUB) begin
                state_next = ST_GROUND;
                push       = 1'b1;
                cmd.kind   = KIND_SUBST;
            end else if (b == CH_ESC) begin
                if (state_reg == ST_OSC) begin
                    push     = 1'b1;
                    cmd.kind = KIND_OSC_END;
                end
                state_next = ST_ESC;
            end else begin
                unique case (state_reg)
                    ST_GROUND: begin
                        push     = 1'b1;
                        cmd.kind = (b <= CH_C0_MAX) ? KIND_EXECUTE : KIND_PRINT;
                    end
                    ST_ESC: begin
                        inter0_next = '0;
                        inter1_next = '0;
                        cur_next    = '0;
                        idx_next    = '0;
                        if (b <= CH_C0_MAX) begin
                            push     = 1'b1;
                            cmd.kind = KIND_EXECUTE;
                        end else if (b <= CH_INT_MAX) begin
                            inter0_next = coll0;
                            inter1_next = coll1;
                            state_next  = ST_ESC_INTER;
                        end else if (b == CH_DCS || b == CH_SOS || b == CH_PM || b == CH_APC) begin
                            state_next = ST_ABSORB;
                        end else if (b == CH_CSI) begin
                            state_next = ST_CSI_ENTRY;
                        end else if (b == CH_OSC) begin
                            osc_cnt_next = '0;
                            state_next   = ST_OSC;
                        end else if (b <= CH_FIN_MAX) begin
                            push       = 1'b1;
                            cmd.kind   = KIND_ESC;
                            state_next = ST_GROUND;
                        end
                    end
                    ST_ESC_INTER: begin
                        if (b <= CH_C0_MAX) begin
                            push     = 1'b1;
                            cmd.kind = KIND_EXECUTE;
                        end else if (b <= CH_INT_MAX) begin
                            inter0_next = coll0;
                            inter1_next = coll1;
                        end else if (b <= CH_FIN_MAX) begin
                            state_next = ST_GROUND;
                            if (inter0_reg != INTER_OVFL) begin
                                push       = 1'b1;
                                cmd.kind   = KIND_ESC;
                                cmd.inter0 = inter0_reg;
                                cmd.inter1 = inter1_reg;
                            end
                        end
                    end
                    ST_CSI_ENTRY, ST_CSI_PARAM, ST_CSI_INTER: begin
                        if (b <= CH_C0_MAX) begin
                            push     = 1'b1;
                            cmd.kind = KIND_EXECUTE;
                        end else if (b <= CH_INT_MAX) begin
                            inter0_next = coll0;
                            inter1_next = coll1;
                            state_next  = ST_CSI_INTER;
                        end else if (b <= CH_QUEST) begin
                            if (state_reg == ST_CSI_INTER || b == CH_COLON) begin
                                state_next = ST_CSI_IGNORE;
                            end else if (b <= CH_SEMI) begin
                                state_next = ST_CSI_PARAM;
                                if (idx_room) begin
                                    if (b == CH_SEMI) begin
                                        store_we = 1'b1;
                                        idx_next = idx_reg + XW'(1);
                                        cur_next = '0;
                                    end else if (acc > 18'(PARAM_SAT)) begin
                                        cur_next = PARAM_SAT;
                                    end else begin
                                        cur_next = acc[VAL_W-1:0];
                                    end
                                end
                            end else if (state_reg == ST_CSI_ENTRY) begin
                                inter0_next = coll0;
                                inter1_next = coll1;
                                state_next  = ST_CSI_PARAM;
                            end else begin
                                state_next = ST_CSI_IGNORE;
                            end
                        end else if (b <= CH_FIN_MAX) begin
                            state_next = ST_GROUND;
                            if (inter0_reg != INTER_OVFL && inter1_reg == '0) begin
                                push         = 1'b1;
                                hold_next    = 1'b1;
                                cmd.kind     = KIND_CSI;
                                cmd.inter0   = inter0_reg;
                                cmd.priv     = (inter0_reg == CH_QUEST);
                                cmd.last_pos = POS_W'(last_pos_int);
                            end
                        end
                    end
                    ST_CSI_IGNORE: begin
                        if (b <= CH_C0_MAX) begin
                            push     = 1'b1;
                            cmd.kind = KIND_EXECUTE;
                        end else if (b >= CH_FIN_MIN && b <= CH_FIN_MAX) begin
                            state_next = ST_GROUND;
                        end
                    end
                    ST_OSC: begin
                        if (b == CH_BEL) begin
                            state_next = ST_GROUND;
                            push       = 1'b1;
                            cmd.kind   = KIND_OSC_END;
                        end else if (b > CH_C0_MAX && int'(osc_cnt_reg) < OSC_LIMIT) begin
                            osc_cnt_next = osc_cnt_reg + CW'(1);
                            push         = 1'b1;
                            cmd.kind     = KIND_OSC;
                        end
                    end
                    ST_ABSORB: begin
                    end
                    default: begin
                        state_next = ST_GROUND;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_GROUND;
            inter0_reg  <= '0;
            inter1_reg  <= '0;
            cur_reg     <= '0;
            idx_reg     <= '0;
            osc_cnt_reg <= '0;
            hold_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            inter0_reg  <= inter0_next;
            inter1_reg  <= inter1_next;
            cur_reg     <= cur_next;
            idx_reg     <= idx_next;
            osc_cnt_reg <= osc_cnt_next;
            hold_reg    <= hold_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (store_we) begin
            store_reg[IW'(idx_reg)] <= cur_reg;
        end
    end

endmodule

`default_nettype wire

@@ hdl/tesp_back.sv @@
// Result back end: turns queued commands into output transactions, one per cycle while the output is not stalled.
`default_nettype none

module tesp_back
    import tesp_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               q_valid,
    input  wire cmd_t               q_cmd,
    output logic                    q_pop,
    output logic                    csi_done,
    output logic [POS_W-1:0]        rd_pos,
    input  wire logic [VAL_W-1:0]   rd_value,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [TDATA_W-1:0]      m_tdata,
    output logic [TUSER_W-1:0]      m_tuser,
    output logic                    m_tlast
);

    logic              m_valid_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [KIND_W-1:0] kind_reg;
    logic [BYTE_W-1:0] code_reg, inter0_reg, inter1_reg;
    logic              priv_reg, last_reg;
    logic [POS_W-1:0]  opos_reg;
    logic [VAL_W-1:0]  value_reg;
    logic              advance;
    logic              is_last;

    assign advance  = !m_valid_reg || m_tready;
    assign is_last  = (pos_reg == q_cmd.last_pos);
    assign q_pop    = advance && q_valid && is_last;
    assign csi_done = q_pop && (q_cmd.kind == KIND_CSI);
    assign rd_pos   = pos_reg;

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = last_reg;
    assign m_tuser  = {priv_reg, kind_reg};
    assign m_tdata  = {6'd0, value_reg, opos_reg, inter1_reg, inter0_reg, code_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            pos_reg     <= '0;
        end else if (advance) begin
            m_valid_reg <= q_valid;
            if (q_valid) begin
                pos_reg <= is_last ? '0 : pos_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && q_valid) begin
            kind_reg   <= q_cmd.kind;
            code_reg   <= q_cmd.code;
            inter0_reg <= q_cmd.inter0;
            inter1_reg <= q_cmd.inter1;
            priv_reg   <= q_cmd.priv;
            opos_reg   <= pos_reg;
            value_reg  <= (q_cmd.kind == KIND_CSI) ? rd_value : '0;
            last_reg   <= is_last;
        end
    end

endmodule

`default_nettype wire

@@ tb/tb_terminal_escape_sequence_parser_top.sv @@
// Self-checking testbench for the terminal escape sequence parser.
`timescale 1ns / 1ps

module tb_terminal_escape_sequence_parser_top;
    import tesp_pkg::*;

    localparam int MAX_PARAMS = 16;
    // The OSC limit is lowered so that long strings overflow it often.
    localparam int OSC_LIMIT  = 48;

    localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;

    typedef enum logic [3:0] {
        P_GROUND, P_ESC, P_ESC_INTER, P_CSI_ENTRY, P_CSI_PARAM,
        P_CSI_INTER, P_CSI_IGNORE, P_DCS, P_OSC, P_STRING
    } parse_state_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] code;
        logic [BYTE_W-1:0] inter0;
        logic [BYTE_W-1:0] inter1;
        logic              priv;
        logic [POS_W-1:0]  pos;
        logic [VAL_W-1:0]  value;
        logic              last;
    } token_t;

    class token_scoreboard;
        token_t            expected_tokens[$];
        int                errors;
        int                checked;
        int                param_tokens;
        parse_state_t      pstate;
        logic [BYTE_W-1:0] inter[2];
        logic [VAL_W-1:0]  params[MAX_PARAMS];
        int                pidx;
        int                osc_cnt;

        function new();
            pstate = P_GROUND;
            inter[0] = '0;
            inter[1] = '0;
            foreach (params[i]) params[i] = '0;
            pidx = 0;
            osc_cnt = 0;
        endfunction

        function void push_token(logic [KIND_W-1:0] k, logic [BYTE_W-1:0] c,
                                 logic [BYTE_W-1:0] i0, logic [BYTE_W-1:0] i1,
                                 logic p, logic [POS_W-1:0] pos,
                                 logic [VAL_W-1:0] v, logic l);
            token_t t;
            t.kind = k;
            t.code = c;
            t.inter0 = i0;
            t.inter1 = i1;
            t.priv = p;
            t.pos = pos;
            t.value = v;
            t.last = l;
            expected_tokens.push_back(t);
        endfunction

        function void push_single(logic [KIND_W-1:0] k, logic [BYTE_W-1:0] c);
            push_token(k, c, '0, '0, 1'b0, '0, '0, 1'b1);
        endfunction

        function void collect_inter(logic [BYTE_W-1:0] b);
            if (inter[0] == '0) begin
                inter[0] = b;
            end else if (inter[1] == '0) begin
                inter[1] = b;
            end else begin
                inter[0] = INTER_OVFL;
            end
        endfunction

        function void add_param_char(logic [BYTE_W-1:0] b);
            int v;
            if (pidx >= MAX_PARAMS) return;
            if (b == CH_SEMI) begin
                pidx++;
                return;
            end
            v = int'(params[pidx]) * 10 + int'(b) - int'(CH_ZERO);
            if (v > int'(PARAM_SAT)) v = int'(PARAM_SAT);
            params[pidx] = VAL_W'(v);
        endfunction

        function void end_esc_seq(logic [BYTE_W-1:0] b);
            pstate = P_GROUND;
            if (inter[0] == INTER_OVFL) return;
            push_token(KIND_ESC, b, inter[0], inter[1], 1'b0, '0, '0, 1'b1);
        endfunction

        function void end_csi_seq(logic [BYTE_W-1:0] b);
            int   n;
            logic priv;
            pstate = P_GROUND;
            if (inter[0] == INTER_OVFL || inter[1] != '0) return;
            priv = (inter[0] == CH_QUEST);
            n = (pidx >= MAX_PARAMS) ? MAX_PARAMS : pidx + 1;
            if (n > RUN_CAP) n = RUN_CAP;
            for (int i = 0; i < n; i++)
                push_token(KIND_CSI, b, inter[0], '0, priv, POS_W'(i), params[i],
                           i == n - 1);
        endfunction

        // Works out the tokens that one accepted input byte causes.
        function void note_byte(logic [BYTE_W-1:0] b);
            if (b == CH_CAN || b == CH_SUB) begin
                pstate = P_GROUND;
                push_single(KIND_SUBST, b);
                return;
            end
            if (b == CH_ESC) begin
                if (pstate == P_OSC) push_single(KIND_OSC_END, b);
                pstate = P_ESC;
                return;
            end
            case (pstate)
                P_GROUND: begin
                    push_single((b <= CH_C0_MAX) ? KIND_EXECUTE : KIND_PRINT, b);
                end
                P_ESC: begin
                    inter[0] = '0;
                    inter[1] = '0;
                    foreach (params[i]) params[i] = '0;
                    pidx = 0;
                    if (b <= CH_C0_MAX) begin
                        push_single(KIND_EXECUTE, b);
                    end else if (b <= CH_INT_MAX) begin
                        collect_inter(b);
                        pstate = P_ESC_INTER;
                    end else if (b == CH_DCS) begin
                        pstate = P_DCS;
                    end else if (b == CH_SOS || b == CH_PM || b == CH_APC) begin
                        pstate = P_STRING;
                    end else if (b == CH_CSI) begin
                        pstate = P_CSI_ENTRY;
                    end else if (b == CH_OSC) begin
                        osc_cnt = 0;
                        pstate = P_OSC;
                    end else if (b <= CH_FIN_MAX) begin
                        end_esc_seq(b);
                    end
                end
                P_ESC_INTER: begin
                    if (b <= CH_C0_MAX) push_single(KIND_EXECUTE, b);
                    else if (b <= CH_INT_MAX) collect_inter(b);
                    else if (b <= CH_FIN_MAX) end_esc_seq(b);
                end
                P_CSI_ENTRY, P_CSI_PARAM: begin
                    if (b <= CH_C0_MAX) begin
                        push_single(KIND_EXECUTE, b);
                    end else if (b <= CH_INT_MAX) begin
                        collect_inter(b);
                        pstate = P_CSI_INTER;
                    end else if (b == CH_COLON) begin
                        pstate = P_CSI_IGNORE;
                    end else if (b <= CH_SEMI) begin
                        add_param_char(b);
                        pstate = P_CSI_PARAM;
                    end else if (b <= CH_QUEST) begin
                        if (pstate == P_CSI_ENTRY) begin
                            collect_inter(b);
                            pstate = P_CSI_PARAM;
                        end else begin
                            pstate = P_CSI_IGNORE;
                        end
                    end else if (b <= CH_FIN_MAX) begin
                        end_csi_seq(b);
                    end
                end
                P_CSI_INTER: begin
                    if (b <= CH_C0_MAX) push_single(KIND_EXECUTE, b);
                    else if (b <= CH_INT_MAX) collect_inter(b);
                    else if (b <= CH_QUEST) pstate = P_CSI_IGNORE;
                    else if (b <= CH_FIN_MAX) end_csi_seq(b);
                end
                P_CSI_IGNORE: begin
                    if (b <= CH_C0_MAX) push_single(KIND_EXECUTE, b);
                    else if (b >= CH_FIN_MIN && b <= CH_FIN_MAX) pstate = P_GROUND;
                end
                P_OSC: begin
                    if (b == CH_BEL) begin
                        pstate = P_GROUND;
                        push_single(KIND_OSC_END, b);
                    end else if (b >= CH_SPACE && osc_cnt < OSC_LIMIT) begin
                        osc_cnt++;
                        push_single(KIND_OSC, b);
                    end
                end
                default: begin
                end
            endcase
        endfunction

        function void mismatch(string what, logic [63:0] exp_v, logic [63:0] act_v);
            errors++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, what, exp_v, act_v);
        endfunction

        function void check_token(logic [TDATA_W-1:0] data, logic [TUSER_W-1:0] user,
                                  logic last);
            token_t e;
            if (expected_tokens.size() == 0) begin
                mismatch("unexpected transaction", '0, 64'({user, data}));
                return;
            end
            e = expected_tokens.pop_front();
            checked++;
            if (e.kind == KIND_CSI) param_tokens++;
            if (user[2:0] !== e.kind)
                mismatch("kind", 64'(e.kind), 64'(user[2:0]));
            if (data[7:0] !== e.code)
                mismatch("char_code", 64'(e.code), 64'(data[7:0]));
            if (data[15:8] !== e.inter0)
                mismatch("first_inter", 64'(e.inter0), 64'(data[15:8]));
            if (data[23:16] !== e.inter1)
                mismatch("second_inter", 64'(e.inter1), 64'(data[23:16]));
            if (user[3] !== e.priv)
                mismatch("private_seq", 64'(e.priv), 64'(user[3]));
            if (data[27:24] !== e.pos)
                mismatch("param_pos", 64'(e.pos), 64'(data[27:24]));
            if (data[41:28] !== e.value)
                mismatch("param_value", 64'(e.value), 64'(data[41:28]));
            if (last !== e.last)
                mismatch("last", 64'(e.last), 64'(last));
        endfunction
    endclass

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [7:0]         s_tdata = 8'h00;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;
    logic [TUSER_W-1:0] m_tuser;
    logic               m_tlast;

    token_scoreboard    sb;
    logic [7:0]         burst[$];
    int                 bytes_sent = 0;
    int                 snd_idle_pct = 0;
    int                 rcv_idle_pct = 0;
    int                 hold_request = 0;
    int                 hold_left = 0;

    terminal_escape_sequence_parser_top #(
        .MAX_PARAMS(MAX_PARAMS),
        .OSC_LIMIT (OSC_LIMIT)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.note_byte(s_tdata);
            if (m_tvalid && m_tready) sb.check_token(m_tdata, m_tuser, m_tlast);
        end
    end

    always @(posedge aclk) begin
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < snd_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        bytes_sent++;
    endtask

    task automatic send_burst();
        foreach (burst[i]) send_byte(burst[i]);
        burst.delete();
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.expected_tokens.size() != 0) @(posedge aclk);
    endtask

    function automatic void gen_print();
        int n;
        n = $urandom_range(8, 1);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < 10) burst.push_back(8'($urandom_range(CH_C0_MAX)));
            else burst.push_back(8'($urandom_range(255, CH_SPACE)));
        end
    endfunction

    function automatic void gen_noise();
        int n;
        n = $urandom_range(4, 1);
        for (int i = 0; i < n; i++) burst.push_back(8'($urandom_range(255)));
    endfunction

    function automatic void gen_esc();
        int r, n;
        burst.push_back(CH_ESC);
        r = $urandom_range(99);
        n = (r < 60) ? 0 : (r < 85) ? 1 : (r < 95) ? 2 : 3;
        for (int i = 0; i < n; i++)
            burst.push_back(8'($urandom_range(CH_INT_MAX, CH_SPACE)));
        burst.push_back(8'($urandom_range(CH_FIN_MAX, CH_ZERO)));
    endfunction

    function automatic void gen_csi(int np_force);
        int r, np, nd;
        burst.push_back(CH_ESC);
        burst.push_back(CH_CSI);
        r = $urandom_range(99);
        if (r < 30) burst.push_back(CH_QUEST);
        else if (r < 42) burst.push_back(8'($urandom_range(CH_QUEST - 1, CH_SEMI + 1)));
        r = $urandom_range(99);
        if (np_force >= 0) np = np_force;
        else if (r < 70) np = $urandom_range(4);
        else if (r < 90) np = $urandom_range(15, 5);
        else np = $urandom_range(20, 16);
        for (int i = 0; i < np; i++) begin
            if (i > 0) burst.push_back(CH_SEMI);
            r = $urandom_range(99);
            nd = (r < 20) ? 0 : (r < 80) ? $urandom_range(3, 1) : $urandom_range(6, 4);
            for (int j = 0; j < nd; j++) burst.push_back(CH_ZERO + 8'($urandom_range(9)));
        end
        r = $urandom_range(99);
        if (r < 6) burst.push_back(CH_COLON);
        else if (r < 10) burst.push_back(CH_QUEST);
        else if (r < 16) burst.push_back(8'($urandom_range(CH_C0_MAX)));
        else if (r < 22) burst.push_back(8'($urandom_range(255, 128)));
        r = $urandom_range(99);
        nd = (r < 82) ? 0 : (r < 94) ? 1 : $urandom_range(3, 2);
        for (int i = 0; i < nd; i++)
            burst.push_back(8'($urandom_range(CH_INT_MAX, CH_SPACE)));
        burst.push_back(8'($urandom_range(CH_FIN_MAX, CH_FIN_MIN)));
    endfunction

    function automatic void gen_osc();
        int r, n;
        burst.push_back(CH_ESC);
        burst.push_back(CH_OSC);
        if ($urandom_range(99) < 85) n = $urandom_range(16);
        else n = $urandom_range(OSC_LIMIT + 8, OSC_LIMIT - 4);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < 10) burst.push_back(8'($urandom_range(CH_C0_MAX)));
            else burst.push_back(8'($urandom_range(255, CH_SPACE)));
        end
        r = $urandom_range(99);
        if (r < 50) begin
            burst.push_back(CH_BEL);
        end else if (r < 90) begin
            burst.push_back(CH_ESC);
            burst.push_back(CH_BSLASH);
        end else begin
            burst.push_back(CH_CAN);
        end
    endfunction

    function automatic void gen_string();
        int n;
        logic [7:0] b;
        burst.push_back(CH_ESC);
        case ($urandom_range(3))
            0: burst.push_back(CH_DCS);
            1: burst.push_back(CH_SOS);
            2: burst.push_back(CH_PM);
            default: burst.push_back(CH_APC);
        endcase
        n = $urandom_range(12);
        for (int i = 0; i < n; i++) begin
            b = 8'($urandom_range(255));
            if (b == CH_ESC || b == CH_CAN || b == CH_SUB) b = CH_ZERO;
            burst.push_back(b);
        end
        burst.push_back(CH_ESC);
        burst.push_back(CH_BSLASH);
    endfunction

    task automatic run_random(input int n_bytes);
        int start, r;
        start = bytes_sent;
        while (bytes_sent - start < n_bytes) begin
            r = $urandom_range(99);
            if (r < 35) gen_csi(-1);
            else if (r < 50) gen_print();
            else if (r < 62) gen_esc();
            else if (r < 77) gen_osc();
            else if (r < 85) gen_string();
            else gen_noise();
            send_burst();
        end
    endtask

    initial begin
        #5_000_000;
        $display("tb_terminal_escape_sequence_parser_top: done, errors");
        $finish;
    end

    initial begin
        sb = new();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        snd_idle_pct = 14;
        rcv_idle_pct = 56;
        burst = '{8'hFF, 8'h00, CH_CAN,
                  CH_ESC, 8'h28, 8'h42,
                  CH_ESC, 8'h21, 8'h22, 8'h23, 8'h30,
                  CH_ESC, CH_CSI, CH_QUEST, 8'h39, 8'h39, 8'h39, 8'h39, 8'h39,
                  8'hFF, 8'h68,
                  CH_ESC, CH_OSC, 8'h41, CH_BEL,
                  CH_ESC, CH_OSC, 8'h42, CH_ESC, CH_BSLASH, CH_SUB};
        send_burst();
        run_random(100);
        wait_idle();

        snd_idle_pct = 56;
        rcv_idle_pct = 14;
        run_random(100);
        wait_idle();

        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        // The receiver stalls long enough for the input side to back up.
        hold_request = 120;
        gen_csi(MAX_PARAMS + 2);
        gen_print();
        gen_print();
        gen_print();
        send_burst();
        wait_idle();
        run_random(100);
        wait_idle();
        repeat (20) @(posedge aclk);

        if (sb.expected_tokens.size() != 0)
            sb.mismatch("pending transaction count", '0,
                        64'(sb.expected_tokens.size()));
        $display("Sent %0d terminal bytes and checked %0d result transactions,",
                 bytes_sent, sb.checked);
        $display("of which %0d were CSI parameters, under mixed and long stalls.",
                 sb.param_tokens);
        if (sb.errors == 0) begin
            $display("tb_terminal_escape_sequence_parser_top: done, clean");
        end else begin
            $display("tb_terminal_escape_sequence_parser_top: done, errors");
        end
        $finish;
    end

endmodule
